// File: hw/rtl/shadow_decal_box_clip_unit_assert.svh
// Assertion macros for the shadow decal box clip unit.
// No dependencies; included by the top level only.
`ifndef SHADOW_DECAL_BOX_CLIP_UNIT_ASSERT_SVH
`define SHADOW_DECAL_BOX_CLIP_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define SDB_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SDB_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/sdbc_pkg.sv
// Shared types and constants for the shadow decal box clip unit.
// No dependencies.
package sdbc_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [15:0] UV_NOM = 16'd21627;
   localparam logic [30:0] Y_LIFT_RST = 31'd6554;
   localparam logic [10:0] MAX_SH_RST = 11'd256;
   localparam logic [0:0] REG_Y_LIFT = 1'b0;
   localparam logic [0:0] REG_MAX_SH = 1'b1;

   typedef struct packed {
      logic        frame_start;
      logic        row_last;
      logic [31:0] caster_x;
      logic [31:0] caster_z;
      logic [30:0] caster_half_x;
      logic [30:0] caster_half_z;
      logic [31:0] caster_top;
      logic [31:0] recv_x;
      logic [31:0] recv_z;
      logic [30:0] recv_half_x;
      logic [30:0] recv_half_z;
      logic [31:0] recv_top;
   } req_type;

   typedef struct packed {
      logic        shadow_made;
      logic        fully_inside;
      logic [31:0] shadow_x;
      logic [31:0] shadow_y;
      logic [31:0] shadow_z;
      logic [30:0] scale_x;
      logic [30:0] scale_z;
      logic [15:0] uv_u;
      logic [15:0] uv_v;
      logic        limit_reached;
   } rsp_type;
endpackage

// File: hw/rtl/sdbc_req_if.sv
// Valid/ready channel interface for request beats.
// Depends on sdbc_pkg.
interface sdbc_req_if import sdbc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sdbc_rsp_if.sv
// Valid/ready channel interface for result beats.
// Depends on sdbc_pkg.
interface sdbc_rsp_if import sdbc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sdbc_divider.sv
// Bit-serial restoring divider: quotient of num by den, one bit per cycle.
// Depends on sdbc_pkg for nothing but house style.
module sdbc_divider import sdbc_pkg::*; #(
   parameter int NW = 48,
   parameter int DW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] c_ff, c_in;
   logic          b_ff, b_in;
   logic [DW:0]   trial;

   // One quotient bit per cycle, remainder restored on a failed subtract.
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; c_in = c_ff; b_in = b_ff;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; c_in = CW'(NW); b_in = 1'b1;
      end else if (b_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         c_in = c_ff - 1'b1;
         if (c_ff == CW'(1)) b_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= 1'b0; c_ff <= '0;
      end else begin
         b_ff <= b_in; c_ff <= c_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = b_ff;
   assign quo  = q_ff;
endmodule

// File: hw/rtl/shadow_decal_box_clip_unit.sv
// Shadow decal box clip unit top level: control, compare and output register.
// Depends on sdbc_pkg, sdbc_req_if, sdbc_rsp_if, sdbc_divider and the assertion header.
`include "shadow_decal_box_clip_unit_assert.svh"
// One caster/receiver pair is handled at a time. A pair that needs no UV offset
// goes through the compare and output states between accepted request beats.
// Each overhanging axis adds a divide on the shared bit-serial divider, one
// quotient bit per cycle over 48 bits. The result beat sits in an output
// register, and the next request beat is taken only once that beat leaves,
// in the same cycle at the earliest.
module shadow_decal_box_clip_unit import sdbc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sdbc_req_if.sink    req,
   sdbc_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CMP = 4'd1, S_DIVX = 4'd2, S_WX = 4'd3,
                          S_DIVZ = 4'd4, S_WZ = 4'd5, S_OUT = 4'd6;
   localparam logic [63:0] LIFT_RST = ((64'd1 << FRAC_BITS) * 64'd2 + 64'd10) / 64'd20;

   logic [3:0]  st_ff, st_in;
   logic [30:0] lift_ff;
   logic [10:0] maxs_ff, cnt_ff, cnt_in;
   logic        lim_ff, lim_in, stop_ff, stop_in;
   req_type     p_ff;
   rsp_type     o_ff, o_in;
   logic        ov_ff, ov_in;
   logic        xmode_ff, xmode_in, zmode_ff, zmode_in; // 1: low edge, else high
   logic        xdo_ff, xdo_in, zdo_ff, zdo_in;
   logic [31:0] dx_ff, dx_in, dz_ff, dz_in;

   // csr writes and reads
   wire cwr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff <= LIFT_RST[30:0]; maxs_ff <= MAX_SH_RST;
      end else if (cwr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_Y_LIFT) lift_ff <= csr_pwdata[30:0];
         else maxs_ff <= csr_pwdata[10:0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_SH) ? {21'd0, maxs_ff} : {1'b0, lift_ff};

   // extended geometry
   logic signed [33:0] cx, cz, chx, chz, rx, rz, rhx, rhz;
   logic signed [33:0] cl, cr, czl, czr, rl, rr, rzl, rzr;
   always_comb begin
      cx = 34'(signed'(p_ff.caster_x)); cz = 34'(signed'(p_ff.caster_z));
      rx = 34'(signed'(p_ff.recv_x));   rz = 34'(signed'(p_ff.recv_z));
      chx = {3'b0, p_ff.caster_half_x}; chz = {3'b0, p_ff.caster_half_z};
      rhx = {3'b0, p_ff.recv_half_x};   rhz = {3'b0, p_ff.recv_half_z};
      cl = cx - chx; cr = cx + chx; czl = cz - chz; czr = cz + chz;
      rl = rx - rhx; rr = rx + rhx; rzl = rz - rhz; rzr = rz + rhz;
   end

   function automatic logic [31:0] sat(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'h7FFFFFFF;
      if (v < -34'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // shared divider for move = (NOM*d + h) / (2h)
   logic        dv_start, dv_busy;
   logic [47:0] dv_num, dv_quo;
   logic [32:0] dv_den;
   logic [30:0] dv_h;
   logic [31:0] dv_d;
   logic        dv_xsel;
   assign dv_xsel = (st_ff == S_DIVX) || (st_ff == S_WX);
   assign dv_h   = dv_xsel ? p_ff.caster_half_x : p_ff.caster_half_z;
   assign dv_d   = dv_xsel ? dx_ff : dz_ff;
   assign dv_num = 48'(dv_d) * 48'(UV_NOM) + 48'(dv_h);
   assign dv_den = {1'b0, dv_h, 1'b0};
   assign dv_start = (st_ff == S_DIVX) || (st_ff == S_DIVZ);
   sdbc_divider #(.NW(48), .DW(33)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num),
      .den(dv_den), .busy(dv_busy), .quo(dv_quo));

   logic [15:0] mv;
   logic        acc;
   always_comb begin
      mv = (dv_h == '0 || dv_quo > 48'(UV_NOM)) ? UV_NOM : dv_quo[15:0];
   end
   assign acc = req.valid && req.ready;
   assign req.ready = (st_ff == S_IDLE) && !(ov_ff && !rsp.ready);

   // sequencer
   logic signed [33:0] yl;
   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff; lim_in = lim_ff; stop_in = stop_ff;
      o_in = o_ff; ov_in = ov_ff && !rsp.ready;
      xmode_in = xmode_ff; zmode_in = zmode_ff; xdo_in = xdo_ff; zdo_in = zdo_ff;
      dx_in = dx_ff; dz_in = dz_ff;
      yl = 34'(signed'(p_ff.recv_top)) + {3'b0, lift_ff};
      case (st_ff)
         S_IDLE: if (acc) st_in = S_CMP;
         S_CMP: begin
            o_in = '0; xdo_in = 1'b0; zdo_in = 1'b0;
            if (p_ff.frame_start) begin
               cnt_in = '0; lim_in = 1'b0; stop_in = 1'b0;
            end
            st_in = S_OUT;
            if (!(p_ff.frame_start ? 1'b0 : stop_ff) &&
                signed'(p_ff.caster_top) >= signed'(p_ff.recv_top)) begin
               o_in.shadow_x = p_ff.caster_x; o_in.shadow_z = p_ff.caster_z;
               o_in.uv_u = UV_NOM; o_in.uv_v = UV_NOM;
               o_in.scale_x = p_ff.caster_half_x; o_in.scale_z = p_ff.caster_half_z;
               o_in.shadow_y = sat(yl);
               if (cl >= rl && cr <= rr && czl >= rzl && czr <= rzr) begin
                  o_in.shadow_made = 1'b1; o_in.fully_inside = 1'b1;
               end else if (cr >= rl && cl <= rr && czr >= rzl && czl <= rzr) begin
                  o_in.shadow_made = 1'b1;
                  if (cr > rl && cl < rl) begin
                     o_in.shadow_x = sat(rl + chx); xdo_in = 1'b1; xmode_in = 1'b1;
                     dx_in = 32'(rl - cl);
                  end else if (cl < rr && cr > rr) begin
                     o_in.shadow_x = sat(rr - chx); xdo_in = 1'b1; xmode_in = 1'b0;
                     dx_in = 32'(cr - rr);
                  end
                  if (czr > rzl && czl < rzl) begin
                     o_in.shadow_z = sat(rzl + chz); zdo_in = 1'b1; zmode_in = 1'b1;
                     dz_in = 32'(rzl - czl);
                  end else if (czl < rzr && czr > rzr) begin
                     o_in.shadow_z = sat(rzr - chz); zdo_in = 1'b1; zmode_in = 1'b0;
                     dz_in = 32'(czr - rzr);
                  end
               end
               if (o_in.shadow_made) begin
                  if (p_ff.frame_start) cnt_in = 11'd1;
                  else if (cnt_ff != 11'h7FF) cnt_in = cnt_ff + 1'b1;
                  if (cnt_in == maxs_ff) lim_in = 1'b1;
                  if (xdo_in) st_in = S_DIVX;
                  else if (zdo_in) st_in = S_DIVZ;
               end else begin
                  o_in = '0;
               end
            end
            if (p_ff.row_last && lim_in) stop_in = 1'b1;
            o_in.limit_reached = lim_in;
         end
         S_DIVX: st_in = S_WX;
         S_WX: if (!dv_busy) begin
            o_in.uv_u = xmode_ff ? UV_NOM - mv : UV_NOM + mv;
            st_in = zdo_ff ? S_DIVZ : S_OUT;
         end
         S_DIVZ: st_in = S_WZ;
         S_WZ: if (!dv_busy) begin
            o_in.uv_v = zmode_ff ? UV_NOM + mv : UV_NOM - mv;
            st_in = S_OUT;
         end
         S_OUT: if (!ov_ff || rsp.ready) begin
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; lim_ff <= 1'b0; stop_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; lim_ff <= lim_in; stop_ff <= stop_in;
         ov_ff <= ov_in;
      end
      if (acc) p_ff <= req.data;
      o_ff <= o_in; xmode_ff <= xmode_in; zmode_ff <= zmode_in;
      xdo_ff <= xdo_in; zdo_ff <= zdo_in; dx_ff <= dx_in; dz_ff <= dz_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.data  = o_ff;

   // checks
   `SDB_ASSERT_IMP(a_no_acc_busy, clock, reset, st_ff != S_IDLE, !req.ready, "ready while busy")
   `SDB_ASSERT_NXT(a_acc_cmp, clock, reset, acc, st_ff == S_CMP, "accepted beat not compared")
   `SDB_ASSERT_IMP(a_empty, clock, reset, rsp.valid && !rsp.data.shadow_made,
      rsp.data.uv_u == '0 && rsp.data.shadow_y == '0, "empty result not zero")
endmodule
